FILE: rtl/lsc_pkg.sv
// shared types and constants for the line segment window clipper
package lsc_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int CFG_ADDR_W          = 4;
  localparam int CFG_DATA_W          = 32;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } lsc_reg_t;

  typedef struct packed {
    logic valid;
    logic reject;
    logic neg_dx;
    logic neg_dy;
  } lsc_ctl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/lsc_div.sv
// pipelined restoring divider, one quotient bit per stage
module lsc_div
  import lsc_pkg::*;
#(
  parameter int DEN_W = 17,
  parameter int QUO_W = 17,
  localparam int NUM_W = DEN_W + QUO_W
) (
  input  logic             clk,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] num_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] num_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (g == 0) begin : g_first
      // top part of the numerator is already below the divisor
      assign rem_in = num_i[NUM_W-1:QUO_W];
      assign num_in = num_i[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign num_in = num_r[g-1];
      assign quo_in = quo_r[g-1];
      assign den_in = den_r[g-1];
    end

    assign trial = {rem_in, num_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[g] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        num_r[g] <= {num_in[QUO_W-2:0], 1'b0};
        quo_r[g] <= {quo_in[QUO_W-2:0], ge};
        den_r[g] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[QUO_W-1];

endmodule

FILE: rtl/lsc_front.sv
// edge ratios, entry/exit selection and exact reject test
module lsc_front
  import lsc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv_i,
  input  logic                         in_valid_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] win_x_min_i,
  input  logic signed [COORD_BITS-1:0] win_y_min_i,
  input  logic signed [COORD_BITS-1:0] win_x_max_i,
  input  logic signed [COORD_BITS-1:0] win_y_max_i,
  output lsc_ctl_t                     ctl_o,
  output logic [COORD_BITS-1:0]        x1_o,
  output logic [COORD_BITS-1:0]        y1_o,
  output logic [COORD_BITS-1:0]        adx_o,
  output logic [COORD_BITS-1:0]        ady_o,
  output logic signed [COORD_BITS:0]   en_o,
  output logic [COORD_BITS-1:0]        ed_o,
  output logic signed [COORD_BITS:0]   xn_o,
  output logic [COORD_BITS-1:0]        xd_o
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C + 2;

  // stage a: deltas and edge distances
  logic signed [C:0] dx, dy, qxl, qxr, qyb, qyt;
  logic              par_nxt;

  logic              a_valid_r, a_par_r, a_negx_r, a_negy_r, a_nzx_r, a_nzy_r;
  logic [C-1:0]      a_x1_r, a_y1_r, a_adx_r, a_ady_r;
  logic signed [C:0] a_enx_r, a_eny_r, a_xnx_r, a_xny_r;

  assign dx  = (C+1)'(end_x_i) - (C+1)'(start_x_i);
  assign dy  = (C+1)'(end_y_i) - (C+1)'(start_y_i);
  assign qxl = (C+1)'(start_x_i) - (C+1)'(win_x_min_i);
  assign qxr = (C+1)'(win_x_max_i) - (C+1)'(start_x_i);
  assign qyb = (C+1)'(start_y_i) - (C+1)'(win_y_min_i);
  assign qyt = (C+1)'(win_y_max_i) - (C+1)'(start_y_i);

  // parallel to an edge and outside it
  assign par_nxt = ((dx == '0) && (qxl < 0 || qxr < 0)) ||
                   ((dy == '0) && (qyb < 0 || qyt < 0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv_i) begin
      a_valid_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      a_par_r  <= par_nxt;
      a_negx_r <= dx[C];
      a_negy_r <= dy[C];
      a_nzx_r  <= (dx != '0);
      a_nzy_r  <= (dy != '0);
      a_x1_r   <= start_x_i;
      a_y1_r   <= start_y_i;
      a_adx_r  <= C'(dx[C] ? -dx : dx);
      a_ady_r  <= C'(dy[C] ? -dy : dy);
      a_enx_r  <= dx[C] ? -qxr : -qxl;
      a_xnx_r  <= dx[C] ? qxl : qxr;
      a_eny_r  <= dy[C] ? -qyt : -qyb;
      a_xny_r  <= dy[C] ? qyb : qyt;
    end
  end

  // stage b: cross products between the two axes
  logic signed [C:0]    adx_s, ady_s;
  logic                 b_valid_r, b_par_r, b_negx_r, b_negy_r, b_nzx_r, b_nzy_r;
  logic [C-1:0]         b_x1_r, b_y1_r, b_adx_r, b_ady_r;
  logic signed [C:0]    b_enx_r, b_eny_r, b_xnx_r, b_xny_r;
  logic signed [PW-1:0] b_eyx_r, b_exy_r, b_xyx_r, b_xxy_r;

  assign adx_s = $signed({1'b0, a_adx_r});
  assign ady_s = $signed({1'b0, a_ady_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv_i) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      b_par_r  <= a_par_r;
      b_negx_r <= a_negx_r;
      b_negy_r <= a_negy_r;
      b_nzx_r  <= a_nzx_r;
      b_nzy_r  <= a_nzy_r;
      b_x1_r   <= a_x1_r;
      b_y1_r   <= a_y1_r;
      b_adx_r  <= a_adx_r;
      b_ady_r  <= a_ady_r;
      b_enx_r  <= a_enx_r;
      b_eny_r  <= a_eny_r;
      b_xnx_r  <= a_xnx_r;
      b_xny_r  <= a_xny_r;
      b_eyx_r  <= PW'(a_eny_r * adx_s);
      b_exy_r  <= PW'(a_enx_r * ady_s);
      b_xyx_r  <= PW'(a_xny_r * adx_s);
      b_xxy_r  <= PW'(a_xnx_r * ady_s);
    end
  end

  // stage c: largest entering ratio, smallest leaving ratio
  logic signed [C:0] en_nxt, xn_nxt;
  logic [C-1:0]      ed_nxt, xd_nxt;
  logic              c_valid_r, c_par_r, c_negx_r, c_negy_r;
  logic [C-1:0]      c_x1_r, c_y1_r, c_adx_r, c_ady_r;
  logic signed [C:0] c_en_r, c_xn_r;
  logic [C-1:0]      c_ed_r, c_xd_r;

  always_comb begin
    logic en_from_x;
    logic xn_from_x;
    en_nxt    = '0;
    ed_nxt    = C'(1);
    en_from_x = 1'b0;
    if (b_nzx_r && b_enx_r > 0) begin
      en_nxt    = b_enx_r;
      ed_nxt    = b_adx_r;
      en_from_x = 1'b1;
    end
    if (b_nzy_r && (en_from_x ? (b_eyx_r > b_exy_r) : (b_eny_r > 0))) begin
      en_nxt = b_eny_r;
      ed_nxt = b_ady_r;
    end
    xn_nxt    = (C+1)'(1);
    xd_nxt    = C'(1);
    xn_from_x = 1'b0;
    if (b_nzx_r && b_xnx_r < $signed({1'b0, b_adx_r})) begin
      xn_nxt    = b_xnx_r;
      xd_nxt    = b_adx_r;
      xn_from_x = 1'b1;
    end
    if (b_nzy_r && (xn_from_x ? (b_xyx_r < b_xxy_r)
                              : (b_xny_r < $signed({1'b0, b_ady_r})))) begin
      xn_nxt = b_xny_r;
      xd_nxt = b_ady_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv_i) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      c_par_r  <= b_par_r;
      c_negx_r <= b_negx_r;
      c_negy_r <= b_negy_r;
      c_x1_r   <= b_x1_r;
      c_y1_r   <= b_y1_r;
      c_adx_r  <= b_adx_r;
      c_ady_r  <= b_ady_r;
      c_en_r   <= en_nxt;
      c_ed_r   <= ed_nxt;
      c_xn_r   <= xn_nxt;
      c_xd_r   <= xd_nxt;
    end
  end

  // stage d: cross products for entry versus exit
  logic              d_valid_r, d_par_r, d_negx_r, d_negy_r;
  logic [C-1:0]      d_x1_r, d_y1_r, d_adx_r, d_ady_r;
  logic signed [C:0] d_en_r, d_xn_r;
  logic [C-1:0]      d_ed_r, d_xd_r;
  logic signed [PW-1:0] d_pe_r, d_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv_i) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      d_par_r  <= c_par_r;
      d_negx_r <= c_negx_r;
      d_negy_r <= c_negy_r;
      d_x1_r   <= c_x1_r;
      d_y1_r   <= c_y1_r;
      d_adx_r  <= c_adx_r;
      d_ady_r  <= c_ady_r;
      d_en_r   <= c_en_r;
      d_ed_r   <= c_ed_r;
      d_xn_r   <= c_xn_r;
      d_xd_r   <= c_xd_r;
      d_pe_r   <= PW'(c_en_r * $signed({1'b0, c_xd_r}));
      d_px_r   <= PW'(c_xn_r * $signed({1'b0, c_ed_r}));
    end
  end

  always_comb begin
    ctl_o.valid  = d_valid_r;
    ctl_o.reject = d_par_r || (d_pe_r > d_px_r);
    ctl_o.neg_dx = d_negx_r;
    ctl_o.neg_dy = d_negy_r;
  end

  assign x1_o  = d_x1_r;
  assign y1_o  = d_y1_r;
  assign adx_o = d_adx_r;
  assign ady_o = d_ady_r;
  assign en_o  = d_en_r;
  assign ed_o  = d_ed_r;
  assign xn_o  = d_xn_r;
  assign xd_o  = d_xd_r;

endmodule

FILE: rtl/line_segment_window_clipper.sv
// line segment window clipper: fully pipelined, one segment per clock while the output is not held
// throughput: one item per cycle while the output is not held; the six dividers take one quotient bit per stage
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset (synchronous, rst_n low) clears all valid bits and the window to zero
module line_segment_window_clipper
  import lsc_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (PARAM_FRAC_BITS + 1) + 4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // enter_param, exit_param, param_span, clipped_start_x, clipped_start_y,
  // clipped_end_x, clipped_end_y
  output logic [OUT_W-1:0]      out_tdata,
  // accepted
  output logic [0:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int C  = COORD_BITS;
  localparam int PW = PARAM_FRAC_BITS + 1;
  localparam int QW = max_int(PW, C);
  localparam int DW = C + 1;
  localparam int NW = QW + DW;

  // window registers
  logic [C-1:0] win_x_min_r, win_y_min_r, win_x_max_r, win_y_max_r;
  lsc_reg_t     cfg_idx;
  logic [C-1:0] rd_sel;

  assign cfg_idx    = lsc_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_min_r <= '0;
      win_y_min_r <= '0;
      win_x_max_r <= '0;
      win_y_max_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_X_MIN: win_x_min_r <= cfg_pwdata[C-1:0];
        REG_Y_MIN: win_y_min_r <= cfg_pwdata[C-1:0];
        REG_X_MAX: win_x_max_r <= cfg_pwdata[C-1:0];
        REG_Y_MAX: win_y_max_r <= cfg_pwdata[C-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_X_MIN: rd_sel = win_x_min_r;
      REG_Y_MIN: rd_sel = win_y_min_r;
      REG_X_MAX: rd_sel = win_x_max_r;
      REG_Y_MAX: rd_sel = win_y_max_r;
      default:   rd_sel = '0;
    endcase
  end

  assign cfg_prdata = CFG_DATA_W'(rd_sel);

  // whole pipeline moves together unless the output item is held
  logic out_valid_r;
  logic adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  lsc_ctl_t          f_ctl;
  logic [C-1:0]      f_x1, f_y1, f_adx, f_ady, f_ed, f_xd;
  logic signed [C:0] f_en, f_xn;

  lsc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv_i      (adv),
    .in_valid_i (in_tvalid),
    .start_x_i  ($signed(in_tdata[C-1:0])),
    .start_y_i  ($signed(in_tdata[2*C-1:C])),
    .end_x_i    ($signed(in_tdata[3*C-1:2*C])),
    .end_y_i    ($signed(in_tdata[4*C-1:3*C])),
    .win_x_min_i($signed(win_x_min_r)),
    .win_y_min_i($signed(win_y_min_r)),
    .win_x_max_i($signed(win_x_max_r)),
    .win_y_max_i($signed(win_y_max_r)),
    .ctl_o      (f_ctl),
    .x1_o       (f_x1),
    .y1_o       (f_y1),
    .adx_o      (f_adx),
    .ady_o      (f_ady),
    .en_o       (f_en),
    .ed_o       (f_ed),
    .xn_o       (f_xn),
    .xd_o       (f_xd)
  );

  // stage f: offset products; a rejected item runs with zero numerators
  logic [C-1:0]   ne_nxt, nx_nxt;
  lsc_ctl_t       p_ctl_r;
  logic [C-1:0]   p_x1_r, p_y1_r, p_ed_r, p_xd_r, p_ne_r, p_nx_r;
  logic [2*C-1:0] p_mxs_r, p_mys_r, p_mxe_r, p_mye_r;

  assign ne_nxt = f_ctl.reject ? '0 : f_en[C-1:0];
  assign nx_nxt = f_ctl.reject ? '0 : f_xn[C-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      p_ctl_r <= f_ctl;
      p_x1_r  <= f_x1;
      p_y1_r  <= f_y1;
      p_ed_r  <= f_ed;
      p_xd_r  <= f_xd;
      p_ne_r  <= ne_nxt;
      p_nx_r  <= nx_nxt;
      p_mxs_r <= (2*C)'(f_adx * ne_nxt);
      p_mys_r <= (2*C)'(f_ady * ne_nxt);
      p_mxe_r <= (2*C)'(f_adx * nx_nxt);
      p_mye_r <= (2*C)'(f_ady * nx_nxt);
    end
  end

  // stage g: numerators with the rounding half added, divisors 2*d
  lsc_ctl_t       g_ctl_r;
  logic [C-1:0]   g_x1_r, g_y1_r;
  logic [NW-1:0]  g_num_r [6];
  logic [DW-1:0]  g_den_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      g_ctl_r    <= p_ctl_r;
      g_x1_r     <= p_x1_r;
      g_y1_r     <= p_y1_r;
      g_num_r[0] <= (NW'(p_ne_r) << PW) + NW'(p_ed_r);
      g_num_r[1] <= (NW'(p_nx_r) << PW) + NW'(p_xd_r);
      g_num_r[2] <= NW'({p_mxs_r, 1'b0}) + NW'(p_ed_r);
      g_num_r[3] <= NW'({p_mys_r, 1'b0}) + NW'(p_ed_r);
      g_num_r[4] <= NW'({p_mxe_r, 1'b0}) + NW'(p_xd_r);
      g_num_r[5] <= NW'({p_mye_r, 1'b0}) + NW'(p_xd_r);
      g_den_r[0] <= {p_ed_r, 1'b0};
      g_den_r[1] <= {p_xd_r, 1'b0};
      g_den_r[2] <= {p_ed_r, 1'b0};
      g_den_r[3] <= {p_ed_r, 1'b0};
      g_den_r[4] <= {p_xd_r, 1'b0};
      g_den_r[5] <= {p_xd_r, 1'b0};
    end
  end

  // quotients: entry, exit, start x/y offsets, end x/y offsets
  logic [QW-1:0] quo [6];

  for (genvar k = 0; k < 6; k++) begin : g_div
    lsc_div #(
      .DEN_W(DW),
      .QUO_W(QW)
    ) u_div (
      .clk  (clk),
      .en_i (adv),
      .num_i(g_num_r[k]),
      .den_i(g_den_r[k]),
      .quo_o(quo[k])
    );
  end

  // side data delayed to line up with the divider outputs
  lsc_ctl_t     s_ctl_r [QW];
  logic [C-1:0] s_x1_r  [QW];
  logic [C-1:0] s_y1_r  [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        s_ctl_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      s_ctl_r[0] <= g_ctl_r;
      s_x1_r[0]  <= g_x1_r;
      s_y1_r[0]  <= g_y1_r;
      for (int i = 1; i < QW; i++) begin
        s_ctl_r[i] <= s_ctl_r[i-1];
        s_x1_r[i]  <= s_x1_r[i-1];
        s_y1_r[i]  <= s_y1_r[i-1];
      end
    end
  end

  // final stage: endpoints and span, zero for a rejected item
  lsc_ctl_t     z_ctl;
  logic [PW-1:0] tin, tout;
  logic [C-1:0]  sx, sy, ex, ey, x1, y1;
  logic          acc_nxt;
  logic [3*PW+4*C-1:0] bits_nxt;
  logic [3*PW+4*C-1:0] out_bits_r;
  logic                out_acc_r;

  assign z_ctl = s_ctl_r[QW-1];
  assign x1    = s_x1_r[QW-1];
  assign y1    = s_y1_r[QW-1];
  assign tin   = PW'(quo[0]);
  assign tout  = PW'(quo[1]);
  assign sx    = z_ctl.neg_dx ? x1 - C'(quo[2]) : x1 + C'(quo[2]);
  assign sy    = z_ctl.neg_dy ? y1 - C'(quo[3]) : y1 + C'(quo[3]);
  assign ex    = z_ctl.neg_dx ? x1 - C'(quo[4]) : x1 + C'(quo[4]);
  assign ey    = z_ctl.neg_dy ? y1 - C'(quo[5]) : y1 + C'(quo[5]);
  assign acc_nxt  = !z_ctl.reject;
  assign bits_nxt = acc_nxt ? {ey, ex, sy, sx, PW'(tout - tin), tout, tin} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= z_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bits_r <= bits_nxt;
      out_acc_r  <= acc_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_W'(out_bits_r);
  assign out_tuser[0] = out_acc_r;

endmodule

FILE: sim/tb_top.sv
// testbench for the line segment window clipper: scoreboard, drivers and checks
`timescale 1ns / 100ps
module tb_top
  import lsc_pkg::*;
();

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int IN_W = 64;
  localparam int OUT_W = 120;
  localparam int LATENCY = 24;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [FB:0] t_in;
    logic [FB:0] t_out;
    logic [FB:0] span;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
    logic acc;
  } clip_t;

  // exact liang-barsky clip against the window, ratios kept as fractions
  class clip_scoreboard;
    logic signed [CB-1:0] win[4] = '{default: '0};
    clip_t pending[$];
    int errors;
    int shown;

    function void set_reg(lsc_reg_t idx, logic [CB-1:0] v);
      win[idx] = v;
    endfunction

    // a/b vs c/d with b, d > 0
    function int frac_cmp(longint a, longint b, longint c, longint d);
      longint l;
      longint r;
      l = a * d;
      r = c * b;
      return (l > r) ? 1 : (l < r) ? -1 : 0;
    endfunction

    function logic [FB:0] param_of(longint n, longint d);
      return (FB + 1)'(((n <<< (FB + 1)) + d) / (2 * d));
    endfunction

    function logic [CB-1:0] coord_at(longint s, longint delta, longint n, longint d);
      longint m;
      longint a;
      a = (delta < 0) ? -delta : delta;
      m = (2 * a * n + d) / (2 * d);
      return CB'((delta < 0) ? s - m : s + m);
    endfunction

    function void note_segment(logic [IN_W-1:0] seg);
      longint x1, y1, x2, y2, dx, dy;
      longint p[4], q[4];
      longint en, ed, xn, xd;
      clip_t r;
      r = '0;
      x1 = $signed(seg[15:0]);
      y1 = $signed(seg[31:16]);
      x2 = $signed(seg[47:32]);
      y2 = $signed(seg[63:48]);
      dx = x2 - x1;
      dy = y2 - y1;
      p[0] = -dx; q[0] = x1 - longint'(win[REG_X_MIN]);
      p[1] = dx;  q[1] = longint'(win[REG_X_MAX]) - x1;
      p[2] = -dy; q[2] = y1 - longint'(win[REG_Y_MIN]);
      p[3] = dy;  q[3] = longint'(win[REG_Y_MAX]) - y1;
      en = 0; ed = 1; xn = 1; xd = 1;
      if ((dx == 0 && (q[0] < 0 || q[1] < 0)) || (dy == 0 && (q[2] < 0 || q[3] < 0))) begin
        pending.push_back(r);
        return;
      end
      for (int i = 0; i < 4; i++) begin
        if (p[i] < 0) begin
          if (frac_cmp(-q[i], -p[i], en, ed) > 0) begin
            en = -q[i]; ed = -p[i];
          end
        end else if (p[i] > 0) begin
          if (frac_cmp(q[i], p[i], xn, xd) < 0) begin
            xn = q[i]; xd = p[i];
          end
        end
      end
      if (frac_cmp(en, ed, xn, xd) <= 0) begin
        r.acc = 1'b1;
        r.t_in = param_of(en, ed);
        r.t_out = param_of(xn, xd);
        r.span = r.t_out - r.t_in;
        r.sx = coord_at(x1, dx, en, ed);
        r.sy = coord_at(y1, dy, en, ed);
        r.ex = coord_at(x1, dx, xn, xd);
        r.ey = coord_at(y1, dy, xn, xd);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic acc);
      clip_t got;
      clip_t exp_r;
      got.t_in = data[16:0];
      got.t_out = data[33:17];
      got.span = data[50:34];
      got.sx = data[66:51];
      got.sy = data[82:67];
      got.ex = data[98:83];
      got.ey = data[114:99];
      got.acc = acc;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h acc %b", data, acc);
        end
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: acc %b/%b in %h/%h out %h/%h span %h/%h",
                   exp_r.acc, got.acc, exp_r.t_in, got.t_in, exp_r.t_out, got.t_out,
                   exp_r.span, got.span);
          $display("  start %0d,%0d/%0d,%0d end %0d,%0d/%0d,%0d",
                   exp_r.sx, exp_r.sy, got.sx, got.sy, exp_r.ex, exp_r.ey, got.ex, got.ey);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  clip_scoreboard clips = new();
  bit sending_done = 1'b0;
  int hold_off = 0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_segment_window_clipper i_dut (.*);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) clips.note_segment(in_tdata);
    if (rst_n && out_tvalid && out_tready) clips.check_result(out_tdata, out_tuser[0]);
  end

  // receiver: a drawn wait before each item, plus an optional long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        while (hold_off > 0) begin
          hold_off--;
          @(negedge clk);
        end
      end
      w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(lsc_reg_t idx, logic signed [CB-1:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata <= {{(CFG_DATA_W - CB){v[CB-1]}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    clips.set_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_window(int xl, int yb, int xr, int yt);
    write_reg(REG_X_MIN, CB'(xl));
    write_reg(REG_Y_MIN, CB'(yb));
    write_reg(REG_X_MAX, CB'(xr));
    write_reg(REG_Y_MAX, CB'(yt));
  endtask

  task automatic drain();
    while (clips.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // drawn gap before the segment when gaps is set, often none
  task automatic send_segment(int x1, int y1, int x2, int y2, bit gaps);
    int w;
    w = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
    if (w > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (w - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {y2[15:0], x2[15:0], y1[15:0], x1[15:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic int coord(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return $signed(16'($urandom()));
      default: return $urandom_range(0, hi - lo) + lo;
    endcase
  endfunction

  task automatic random_phase(int n, int xl, int yb, int xr, int yt);
    int lx, ly, hx, hy;
    set_window(xl, yb, xr, yt);
    lx = (xl < xr ? xl : xr) - 300; hx = (xl < xr ? xr : xl) + 300;
    ly = (yb < yt ? yb : yt) - 300; hy = (yb < yt ? yt : yb) + 300;
    if (lx < -32768) lx = -32768;
    if (ly < -32768) ly = -32768;
    if (hx > 32767) hx = 32767;
    if (hy > 32767) hy = 32767;
    for (int i = 0; i < n; i++) begin
      int x1, y1, x2, y2;
      x1 = coord(lx, hx); y1 = coord(ly, hy);
      case ($urandom_range(0, 5))
        0: begin x2 = x1; y2 = coord(ly, hy); end
        1: begin x2 = coord(lx, hx); y2 = y1; end
        2: begin x2 = x1; y2 = y1; end
        default: begin x2 = coord(lx, hx); y2 = coord(ly, hy); end
      endcase
      send_segment(x1, y1, x2, y2, 1'b1);
    end
    end_burst();
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset window is the single point at the origin
    send_segment(0, 0, 0, 0, 1'b0);
    send_segment(-5, 0, 5, 0, 1'b0);
    end_burst();
    drain();
    set_window(-100, -50, 100, 50);
    send_segment(-200, 0, 200, 0, 1'b0);
    send_segment(0, 0, 10, 10, 1'b0);
    send_segment(-200, 100, 200, 100, 1'b0);
    send_segment(300, -300, 300, 300, 1'b0);
    send_segment(-300, -300, 300, 300, 1'b0);
    send_segment(-300, 0, -200, 300, 1'b0);
    send_segment(7, 7, 7, 7, 1'b0);
    send_segment(500, 500, 500, 500, 1'b0);
    send_segment(-32768, -32768, 32767, 32767, 1'b0);
    send_segment(32767, -32768, -32768, 32767, 1'b0);
    send_segment(-100, -50, 100, 50, 1'b0);
    send_segment(1, 0, 4, 3, 1'b0);
    send_segment(-32768, 1, 32767, -1, 1'b0);
    send_segment(101, -60, 99, -40, 1'b0);
    end_burst();
    drain();
    // inverted window on x
    set_window(100, -50, -100, 50);
    send_segment(0, 0, 0, 0, 1'b0);
    send_segment(-200, 0, 200, 0, 1'b0);
    end_burst();
    drain();
    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, -32768, 32767, 32767, 1'b0);
    send_segment(32767, 32767, -32768, -32768, 1'b0);
    send_segment(-32768, 32767, 32767, -32768, 1'b0);
    end_burst();
    drain();
    // long receiver hold-off while the sender keeps pushing
    set_window(-1000, -1000, 1000, 1000);
    hold_off = 120;
    for (int i = 0; i < 80; i++)
      send_segment(coord(-2000, 2000), coord(-2000, 2000),
                   coord(-2000, 2000), coord(-2000, 2000), 1'b0);
    end_burst();
    drain();
    random_phase(250, -1000, -800, 1200, 900);
    random_phase(200, -40, -30, 25, 60);
    random_phase(150, -32768, -32768, 32767, 32767);
    random_phase(100, 30000, -32768, 32767, -30000);
    random_phase(80, 5, 5, -5, 5);
    random_phase(100, $signed(16'($urandom())), $signed(16'($urandom())),
                 $signed(16'($urandom())), $signed(16'($urandom())));
    write_reg(REG_X_MIN, 0);
    if (clips.errors == 0 && clips.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
